// ===== sv/wsdf_pkg.sv =====
// ----------------------------------------------------------------------------
// wsdf_pkg
// Shared constants for the WebSocket frame deframer: event codes, opcodes
// and header length codes.
// ----------------------------------------------------------------------------
package wsdf_pkg;

    // Event codes carried on the result channel
    typedef logic [1:0] event_t;
    localparam event_t EV_PAYLOAD   = 2'd0;
    localparam event_t EV_EMPTY     = 2'd1;
    localparam event_t EV_FRAG_ERR  = 2'd2;
    localparam event_t EV_OPCODE_ERR = 2'd3;

    // Frame opcodes accepted by the parser
    typedef logic [3:0] opcode_t;
    localparam opcode_t OP_TEXT  = 4'h1;
    localparam opcode_t OP_CLOSE = 4'h8;
    localparam opcode_t OP_PING  = 4'h9;
    localparam opcode_t OP_PONG  = 4'hA;

    // Second header byte length codes
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

endpackage

// ===== sv/websocket_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top
// Receive-side WebSocket frame parser: header decode, unmasking, events.
// ----------------------------------------------------------------------------
// The block takes one stream byte per clock and returns its result, if any,
// from an output register in the next cycle. Each byte updates the header
// parser state with a single pass of logic (a 64-bit length shift or
// decrement and compare being the widest path), so a new byte is taken in
// every cycle in which the output register is empty or being drained.
// Header bytes give no result except a one-item empty frame event; payload
// bytes come out unmasked and tagged with the frame opcode, the final one
// with tlast set. A non-final frame or an unsupported opcode gives an error
// event at the first header byte, after which all input is dropped until
// reset.
module websocket_frame_deframer_top
    import wsdf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // Received byte stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] rx_byte
    // Result stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] payload_byte
    output logic [5:0] m_tuser,    // [1:0] event_res, [5:2] frame_opcode
    output logic       m_tlast     // last
);

    // Parser phases
    localparam logic [2:0] PH_HDR1  = 3'd0;
    localparam logic [2:0] PH_HDR2  = 3'd1;
    localparam logic [2:0] PH_EXT16 = 3'd2;
    localparam logic [2:0] PH_EXT64 = 3'd3;
    localparam logic [2:0] PH_KEY   = 3'd4;
    localparam logic [2:0] PH_DATA  = 3'd5;

    logic [2:0]  phase_reg,       phase_next;
    opcode_t     held_op_reg,     held_op_next;
    logic        mask_on_reg,     mask_on_next;
    logic [63:0] remain_reg,      remain_next;
    logic [2:0]  hdr_cnt_reg,     hdr_cnt_next;
    logic [31:0] key_reg,         key_next;
    logic [1:0]  key_pos_reg,     key_pos_next;
    logic        halt_reg,        halt_next;

    logic        out_valid_reg,   out_valid_next;
    event_t      out_event_reg;
    logic [7:0]  out_byte_reg;
    opcode_t     out_op_reg;
    logic        out_last_reg;

    logic        accept;
    logic        res_valid;
    event_t      res_event;
    logic [7:0]  res_byte;
    opcode_t     res_op;
    logic        res_last;

    logic [7:0]  key_byte;
    logic [63:0] remain_shift;
    logic        ext_done;
    opcode_t     in_op;

    // Handshake: output register decouples the two sides
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign in_op        = s_tdata[3:0];
    assign remain_shift = {remain_reg[55:0], s_tdata};
    assign ext_done     = (phase_reg == PH_EXT16) ? (hdr_cnt_reg == 3'd1)
                                                  : (hdr_cnt_reg == 3'd7);

    // Mask key byte for the current payload position, first key byte on top
    always_comb
    begin
        case (key_pos_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    // Per-byte parser update
    always_comb
    begin
        phase_next   = phase_reg;
        held_op_next = held_op_reg;
        mask_on_next = mask_on_reg;
        remain_next  = remain_reg;
        hdr_cnt_next = hdr_cnt_reg;
        key_next     = key_reg;
        key_pos_next = key_pos_reg;
        halt_next    = halt_reg;
        res_valid    = 1'b0;
        res_event    = EV_PAYLOAD;
        res_byte     = 8'd0;
        res_op       = held_op_reg;
        res_last     = 1'b0;

        if (!halt_reg)
        begin
            unique case (phase_reg) inside
                PH_HDR2:
                begin
                    mask_on_next = s_tdata[7];
                    key_next     = 32'd0;
                    key_pos_next = 2'd0;
                    hdr_cnt_next = 3'd0;
                    remain_next  = 64'd0;
                    if (s_tdata[6:0] == LEN_EXT16)
                        phase_next = PH_EXT16;
                    else if (s_tdata[6:0] == LEN_EXT64)
                        phase_next = PH_EXT64;
                    else
                    begin
                        remain_next = {57'd0, s_tdata[6:0]};
                        if (s_tdata[7])
                            phase_next = PH_KEY;
                        else if (s_tdata[6:0] == 7'd0)
                        begin
                            phase_next = PH_HDR1;
                            res_valid  = 1'b1;
                            res_event  = EV_EMPTY;
                            res_last   = 1'b1;
                        end
                        else
                            phase_next = PH_DATA;
                    end
                end

                PH_EXT16, PH_EXT64:
                begin
                    remain_next = remain_shift;
                    if (ext_done)
                    begin
                        hdr_cnt_next = 3'd0;
                        if (mask_on_reg)
                            phase_next = PH_KEY;
                        else if (remain_shift == 64'd0)
                        begin
                            phase_next = PH_HDR1;
                            res_valid  = 1'b1;
                            res_event  = EV_EMPTY;
                            res_last   = 1'b1;
                        end
                        else
                            phase_next = PH_DATA;
                    end
                    else
                        hdr_cnt_next = hdr_cnt_reg + 3'd1;
                end

                PH_KEY:
                begin
                    key_next = {key_reg[23:0], s_tdata};
                    if (hdr_cnt_reg >= 3'd3)
                    begin
                        hdr_cnt_next = 3'd0;
                        if (remain_reg == 64'd0)
                        begin
                            phase_next = PH_HDR1;
                            res_valid  = 1'b1;
                            res_event  = EV_EMPTY;
                            res_last   = 1'b1;
                        end
                        else
                            phase_next = PH_DATA;
                    end
                    else
                        hdr_cnt_next = hdr_cnt_reg + 3'd1;
                end

                PH_DATA:
                begin
                    res_valid    = 1'b1;
                    res_event    = EV_PAYLOAD;
                    res_byte     = s_tdata ^ key_byte;
                    key_pos_next = key_pos_reg + 2'd1;
                    if (remain_reg <= 64'd1)
                    begin
                        res_last    = 1'b1;
                        remain_next = 64'd0;
                        phase_next  = PH_HDR1;
                    end
                    else
                        remain_next = remain_reg - 64'd1;
                end

                // First header byte; unused phase codes land here too
                default:
                begin
                    res_op = in_op;
                    if (!s_tdata[7])
                    begin
                        halt_next = 1'b1;
                        res_valid = 1'b1;
                        res_event = EV_FRAG_ERR;
                    end
                    else if (in_op != OP_TEXT && in_op != OP_CLOSE &&
                             in_op != OP_PING && in_op != OP_PONG)
                    begin
                        halt_next = 1'b1;
                        res_valid = 1'b1;
                        res_event = EV_OPCODE_ERR;
                    end
                    else
                    begin
                        held_op_next = in_op;
                        phase_next   = PH_HDR2;
                    end
                end
            endcase
        end
    end

    // Output valid tracking
    always_comb
    begin
        if (accept)
            out_valid_next = res_valid;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Parser state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HDR1;
            held_op_reg   <= 4'd0;
            mask_on_reg   <= 1'b0;
            remain_reg    <= 64'd0;
            hdr_cnt_reg   <= 3'd0;
            key_reg       <= 32'd0;
            key_pos_reg   <= 2'd0;
            halt_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                phase_reg   <= phase_next;
                held_op_reg <= held_op_next;
                mask_on_reg <= mask_on_next;
                remain_reg  <= remain_next;
                hdr_cnt_reg <= hdr_cnt_next;
                key_reg     <= key_next;
                key_pos_reg <= key_pos_next;
                halt_reg    <= halt_next;
            end
        end
    end

    // Result payload register
    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
        begin
            out_event_reg <= res_event;
            out_byte_reg  <= res_byte;
            out_op_reg    <= res_op;
            out_last_reg  <= res_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = {out_op_reg, out_event_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ===== sv/wsdf_checker.sv =====
// ----------------------------------------------------------------------------
// wsdf_checker
// Port-level checks on the deframer result stream.
// ----------------------------------------------------------------------------
module wsdf_checker
    import wsdf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic [5:0] m_tuser,
    input  logic       m_tlast
);

    // Stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    // Non-payload events carry a zero data byte
    a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1:0] != EV_PAYLOAD |-> m_tdata == 8'd0)
        else $error("event carries data");

    // Empty frame closes the frame; errors never do
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[1:0] == EV_EMPTY && m_tlast)
            || (m_tuser[1:0] == EV_PAYLOAD)
            || ((m_tuser[1:0] == EV_FRAG_ERR || m_tuser[1:0] == EV_OPCODE_ERR) && !m_tlast))
        else $error("tlast inconsistent with event");

    // After an error is delivered the block stays silent
    a_halt: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tuser[1] |=> !m_tvalid)
        else $error("result after error");

    // A new result only follows an accepted input request
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !$past(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("result without input request");

endmodule

bind websocket_frame_deframer_top wsdf_checker u_wsdf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
